// ----- sv/ffpa_pkg.sv -----
// Shared types and codes of the first-fit partition allocator.
// Holds the request/response transaction structs, status codes, cell ops and FSM states.
// No dependencies; every other file uses this package.
package ffpa_pkg;

    localparam int ID_W       = 8;
    localparam int SIZE_W     = 8;
    localparam int ADDR_OUT_W = 7;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_ffpa_status;

    // Operation broadcast to every cell of the table during the table update.
    typedef enum logic [2:0] {
        OP_HOLD,     // keep contents
        OP_TAKE,     // exact fit: selected entry becomes busy
        OP_SPLIT,    // split selected entry, shift the tail up one place
        OP_FREE,     // release selected entry, no merge
        OP_FREE_L,   // release and merge into the left neighbor
        OP_FREE_R,   // release and absorb the right neighbor
        OP_FREE_LR   // release and merge both neighbors into the left one
    } t_ffpa_op;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_FIND,
        FSM_APPLY
    } t_ffpa_fsm;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   task_id;
        logic [SIZE_W-1:0] request_size;
    } t_ffpa_req;

    typedef struct packed {
        t_ffpa_status          status;
        logic [ADDR_OUT_W-1:0] start_address;
    } t_ffpa_rsp;

    // Broadcast from the controller to all cells.
    typedef struct packed {
        t_ffpa_op          op;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } t_ffpa_ctl;

    // Where a cell sits relative to the selected entry.
    typedef struct packed {
        logic self;    // this cell is the selected entry
        logic left;    // left neighbor is the selected entry
        logic right;   // right neighbor is the selected entry
        logic after;   // selected entry lies somewhere to the left
    } t_ffpa_pos;

    // Per-cell match flags toward the controller.
    typedef struct packed {
        logic hit;     // busy and owned by the request id
        logic fit;     // free and long enough
        logic exact;   // length equals the request size
        logic free;    // in use by the table and free
    } t_ffpa_flags;

endpackage

// ----- sv/ffpa_cell.sv -----
// One entry of the partition table: start, length, owner and busy flag.
// Updates from its neighbors under the op broadcast by ffpa_ctrl.
// Depends on ffpa_pkg.
module ffpa_cell #(
    parameter int MEM_UNITS = 128,
    parameter int IDX       = 0
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  ffpa_pkg::t_ffpa_ctl                                i_ctl,
    input  ffpa_pkg::t_ffpa_pos                                i_pos,
    input  logic [$clog2(MEM_UNITS+1)-1:0]                     i_count,
    input  logic [$clog2(MEM_UNITS)+$clog2(MEM_UNITS+1)+8:0]   i_left,
    input  logic [$clog2(MEM_UNITS)+$clog2(MEM_UNITS+1)+8:0]   i_right1,
    input  logic [$clog2(MEM_UNITS)+$clog2(MEM_UNITS+1)+8:0]   i_right2,
    output logic [$clog2(MEM_UNITS)+$clog2(MEM_UNITS+1)+8:0]   o_entry,
    output ffpa_pkg::t_ffpa_flags                              o_flags
);
    import ffpa_pkg::*;

    localparam int AW   = $clog2(MEM_UNITS);
    localparam int LW   = $clog2(MEM_UNITS+1);
    localparam int CW   = LW;
    localparam int EW   = AW + LW + ID_W + 1;
    localparam int CMPW = (LW > SIZE_W) ? LW : SIZE_W;

    logic [AW-1:0]   r_start, n_start;
    logic [LW-1:0]   r_len,   n_len;
    logic [ID_W-1:0] r_owner, n_owner;
    logic            r_busy,  n_busy;

    logic [AW-1:0]   l_start, r1_start, r2_start;
    logic [LW-1:0]   l_len,   r1_len,   r2_len;
    logic [ID_W-1:0] l_owner, r1_owner, r2_owner;
    logic            l_busy,  r1_busy,  r2_busy;
    logic            w_inr;
    logic [CMPW-1:0] w_len_x, w_size_x;

    assign {l_busy,  l_owner,  l_len,  l_start}  = i_left[EW-1:0];
    assign {r1_busy, r1_owner, r1_len, r1_start} = i_right1[EW-1:0];
    assign {r2_busy, r2_owner, r2_len, r2_start} = i_right2[EW-1:0];

    assign o_entry = {r_busy, r_owner, r_len, r_start};

    assign w_inr    = CW'(IDX) < i_count;
    assign w_len_x  = CMPW'(r_len);
    assign w_size_x = CMPW'(i_ctl.size);

    assign o_flags.hit   = w_inr & r_busy & (r_owner == i_ctl.id);
    assign o_flags.fit   = w_inr & ~r_busy & (w_len_x >= w_size_x);
    assign o_flags.exact = w_len_x == w_size_x;
    assign o_flags.free  = w_inr & ~r_busy;

    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_owner = r_owner;
        n_busy  = r_busy;
        case (i_ctl.op)
            OP_TAKE: begin
                if (i_pos.self) begin
                    n_owner = i_ctl.id;
                    n_busy  = 1'b1;
                end
            end
            OP_SPLIT: begin
                if (i_pos.self) begin
                    n_len   = LW'(i_ctl.size);
                    n_owner = i_ctl.id;
                    n_busy  = 1'b1;
                end else if (i_pos.left) begin
                    // free remainder behind the new busy part
                    n_start = l_start + AW'(i_ctl.size);
                    n_len   = l_len - LW'(i_ctl.size);
                    n_owner = '0;
                    n_busy  = 1'b0;
                end else if (i_pos.after) begin
                    {n_busy, n_owner, n_len, n_start} = {l_busy, l_owner, l_len, l_start};
                end
            end
            OP_FREE: begin
                if (i_pos.self) begin
                    n_owner = '0;
                    n_busy  = 1'b0;
                end
            end
            OP_FREE_L: begin
                if (i_pos.right) begin
                    n_len = r_len + r1_len;
                end else if (i_pos.self || i_pos.after) begin
                    {n_busy, n_owner, n_len, n_start} = {r1_busy, r1_owner, r1_len, r1_start};
                end
            end
            OP_FREE_R: begin
                if (i_pos.self) begin
                    n_len   = r_len + r1_len;
                    n_owner = '0;
                    n_busy  = 1'b0;
                end else if (i_pos.after) begin
                    {n_busy, n_owner, n_len, n_start} = {r1_busy, r1_owner, r1_len, r1_start};
                end
            end
            OP_FREE_LR: begin
                if (i_pos.right) begin
                    n_len = r_len + r1_len + r2_len;
                end else if (i_pos.self || i_pos.after) begin
                    {n_busy, n_owner, n_len, n_start} = {r2_busy, r2_owner, r2_len, r2_start};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_len   <= (IDX == 0) ? LW'(MEM_UNITS) : '0;
            r_owner <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_start <= n_start;
            r_len   <= n_len;
            r_owner <= n_owner;
            r_busy  <= n_busy;
        end
    end

endmodule

// ----- sv/ffpa_ctrl.sv -----
// Sequencer of the allocator: takes a request, finds the first matching cell,
// picks the table op and the status, and holds the response register.
// Depends on ffpa_pkg.
module ffpa_ctrl #(
    parameter int MEM_UNITS = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  ffpa_pkg::t_ffpa_req                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output ffpa_pkg::t_ffpa_rsp                  o_out_data,
    input  ffpa_pkg::t_ffpa_flags                i_flags [MEM_UNITS],
    input  logic [$clog2(MEM_UNITS)-1:0]         i_start [MEM_UNITS],
    output logic [MEM_UNITS-1:0]                 o_first,
    output logic [MEM_UNITS-1:0]                 o_after,
    output ffpa_pkg::t_ffpa_ctl                  o_ctl,
    output logic [$clog2(MEM_UNITS+1)-1:0]       o_count
);
    import ffpa_pkg::*;

    localparam int N  = MEM_UNITS;
    localparam int AW = $clog2(MEM_UNITS);
    localparam int CW = $clog2(MEM_UNITS+1);

    t_ffpa_fsm              r_state, n_state;
    t_ffpa_req              r_req;
    logic [N-1:0]           r_first, r_after;
    logic                   r_any, r_dup;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    t_ffpa_rsp              r_out_data, n_out_data;

    logic [N-1:0]           w_hit, w_fit, w_exact, w_free, w_match, w_pre;
    logic                   w_exact_sel, w_lfree, w_rfree, w_out_free, w_accept;
    logic [AW-1:0]          w_start_sel;
    logic [AW+ADDR_OUT_W-1:0] w_addr_ext;
    t_ffpa_op               w_op;

    assign o_in_stall  = !i_rst_n || (r_state != FSM_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_first  = r_first;
    assign o_after  = r_after;
    assign o_count  = r_count;
    assign o_ctl.op   = w_op;
    assign o_ctl.id   = r_req.task_id;
    assign o_ctl.size = r_req.request_size;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_hit[j]   = i_flags[j].hit;
            w_fit[j]   = i_flags[j].fit;
            w_exact[j] = i_flags[j].exact;
            w_free[j]  = i_flags[j].free;
        end
        w_match = (r_req.req_type == REQ_FREE) ? w_hit : w_fit;
    end

    // log-depth inclusive prefix OR over the match vector
    always_comb begin
        w_pre = w_match;
        for (int s = 1; s < N; s = s * 2) begin
            w_pre = w_pre | (w_pre << s);
        end
    end

    always_comb begin
        w_start_sel = '0;
        for (int j = 0; j < N; j++) begin
            w_start_sel = w_start_sel | (r_first[j] ? i_start[j] : '0);
        end
        w_exact_sel = |(r_first & w_exact);
        w_lfree     = |(r_first[N-1:1] & w_free[N-2:0]);
        w_rfree     = |(r_first[N-2:0] & w_free[N-1:1]);
        w_addr_ext  = {{ADDR_OUT_W{1'b0}}, w_start_sel};
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_op        = OP_HOLD;
        case (r_state)
            FSM_IDLE: begin
                if (w_accept) begin
                    n_state = FSM_FIND;
                end
            end
            FSM_FIND: begin
                n_state = FSM_APPLY;
            end
            FSM_APPLY: begin
                if (w_out_free) begin
                    n_state                  = FSM_IDLE;
                    n_out_valid              = 1'b1;
                    n_out_data.status        = ST_OK;
                    n_out_data.start_address = '0;
                    if (r_req.req_type == REQ_ALLOC) begin
                        if (r_req.task_id == '0 || r_req.request_size == '0) begin
                            n_out_data.status = ST_INVALID;
                        end else if (r_dup) begin
                            n_out_data.status = ST_DUP;
                        end else if (!r_any) begin
                            n_out_data.status = ST_NOSPACE;
                        end else if (w_exact_sel) begin
                            w_op                     = OP_TAKE;
                            n_out_data.start_address = w_addr_ext[ADDR_OUT_W-1:0];
                        end else if (r_count >= CW'(MEM_UNITS)) begin
                            n_out_data.status = ST_NOSPACE;
                        end else begin
                            w_op                     = OP_SPLIT;
                            n_count                  = r_count + CW'(1);
                            n_out_data.start_address = w_addr_ext[ADDR_OUT_W-1:0];
                        end
                    end else begin
                        if (r_req.task_id == '0) begin
                            n_out_data.status = ST_INVALID;
                        end else if (!r_any) begin
                            n_out_data.status = ST_NOTFOUND;
                        end else if (w_lfree && w_rfree) begin
                            w_op    = OP_FREE_LR;
                            n_count = r_count - CW'(2);
                        end else if (w_lfree) begin
                            w_op    = OP_FREE_L;
                            n_count = r_count - CW'(1);
                        end else if (w_rfree) begin
                            w_op    = OP_FREE_R;
                            n_count = r_count - CW'(1);
                        end else begin
                            w_op = OP_FREE;
                        end
                    end
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (r_state == FSM_FIND) begin
            r_first <= w_match & ~{w_pre[N-2:0], 1'b0};
            r_after <= {w_pre[N-2:0], 1'b0};
            r_any   <= |w_match;
            r_dup   <= |w_hit;
        end
    end

endmodule

// ----- sv/first_fit_partition_allocator.sv -----
// Top level of the first-fit partition allocator: a row of ffpa_cell entries
// driven by the ffpa_ctrl sequencer. Depends on ffpa_pkg, ffpa_cell, ffpa_ctrl.
//
//  channel | direction | handshake             | transaction payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | to block  | i_in_valid/o_in_stall | t_ffpa_req: req_type, task_id, request_size
//  out     | from block| o_out_valid/i_out_stall | t_ffpa_rsp: status, start_address
//
// The response register loads as the request leaves FSM_APPLY: FSM_FIND runs the
// first-match search (prefix OR over the cell flags), FSM_APPLY the table update, in which
// every cell loads from itself or a neighbor. The next request is taken back in FSM_IDLE,
// so no new request enters before the response of the last one is loaded.
// The update waits while the previous response is still held by the consumer.
// Reset (synchronous, active low) makes cell 0 one free partition over all MEM_UNITS units
// and the entry count 1; no clearing pass. o_in_stall is high during reset.
module first_fit_partition_allocator #(
    parameter int MEM_UNITS = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ffpa_pkg::t_ffpa_req  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ffpa_pkg::t_ffpa_rsp  o_out_data
);
    import ffpa_pkg::*;

    localparam int AW = $clog2(MEM_UNITS);
    localparam int LW = $clog2(MEM_UNITS+1);
    localparam int EW = AW + LW + ID_W + 1;

    // packed entry per cell: {busy, owner, length, start}
    logic [EW-1:0]          w_entry [MEM_UNITS];
    logic [AW-1:0]          w_start [MEM_UNITS];
    t_ffpa_flags            w_flags [MEM_UNITS];
    logic [MEM_UNITS-1:0]   w_first, w_after;
    t_ffpa_ctl              w_ctl;
    logic [LW-1:0]          w_count;

    ffpa_ctrl #(
        .MEM_UNITS (MEM_UNITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_flags     (w_flags),
        .i_start     (w_start),
        .o_first     (w_first),
        .o_after     (w_after),
        .o_ctl       (w_ctl),
        .o_count     (w_count)
    );

    // Build the table as a chain: each cell sees its left neighbor and the two to its right.
    for (genvar j = 0; j < MEM_UNITS; j++) begin : g_cell
        logic [EW-1:0] w_left, w_right1, w_right2;
        t_ffpa_pos     w_pos;

        if (j > 0) begin : g_l
            assign w_left      = w_entry[j-1];
            assign w_pos.left  = w_first[j-1];
        end else begin : g_l0
            assign w_left      = '0;
            assign w_pos.left  = 1'b0;
        end

        if (j + 1 < MEM_UNITS) begin : g_r1
            assign w_right1    = w_entry[j+1];
            assign w_pos.right = w_first[j+1];
        end else begin : g_r1e
            assign w_right1    = '0;
            assign w_pos.right = 1'b0;
        end

        if (j + 2 < MEM_UNITS) begin : g_r2
            assign w_right2 = w_entry[j+2];
        end else begin : g_r2e
            assign w_right2 = '0;
        end

        assign w_pos.self  = w_first[j];
        assign w_pos.after = w_after[j];
        assign w_start[j]  = w_entry[j][AW-1:0];

        ffpa_cell #(
            .MEM_UNITS (MEM_UNITS),
            .IDX       (j)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_pos    (w_pos),
            .i_count  (w_count),
            .i_left   (w_left),
            .i_right1 (w_right1),
            .i_right2 (w_right2),
            .o_entry  (w_entry[j]),
            .o_flags  (w_flags[j])
        );
    end

endmodule

// ----- sv/ffpa_checker.sv -----
// Port-level checks of the first-fit partition allocator, bound to its top level.
// Depends on ffpa_pkg and first_fit_partition_allocator.
module ffpa_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input ffpa_pkg::t_ffpa_req  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input ffpa_pkg::t_ffpa_rsp  o_out_data
);

    // A taken request blocks the input until its response is loaded.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request transaction");

    // A response only appears while a request is in flight.
    a_out_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("response appeared without a pending request");

    // Failed requests report address zero.
    a_addr_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ffpa_pkg::ST_OK)
            |-> (o_out_data.start_address == '0))
        else $error("nonzero address on a failed request");

    // Hold a stalled response.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled response changed");

endmodule

bind first_fit_partition_allocator ffpa_checker u_ffpa_checker (.*);
